// ===== hw/rtl/chxy_pkg.sv =====
// Package for the compass heading block: widths, fixed-point formats,
// register codes, the arctangent table and the shared struct types.
// No dependencies.
package chxy_pkg;

  // Number of CORDIC micro-rotations, capped by the table length
  localparam int ANGLE_STEPS = 16;
  localparam int TABLE_LEN   = 24;
  localparam int NUM_STEPS   = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;
  localparam int SHIFT_W     = $clog2(TABLE_LEN);

  // Field and datapath widths
  localparam int RD_W      = 13;  // raw reading and offset
  localparam int DIFF_W    = 14;  // reading minus offset, exact
  localparam int FRAC_BITS = 16;  // vector is carried in Q16
  localparam int VEC_W     = 33;  // holds Q16 vector plus CORDIC gain
  localparam int ANGLE_W   = 32;  // binary angle, 2^32 units per turn
  localparam int HEAD_W    = 15;  // heading in 1/64 degree
  localparam int PROD_W    = ANGLE_W + HEAD_W;

  // Headings in 1/64 degree
  localparam logic [HEAD_W-1:0] FULL_TURN     = 15'd23040;
  localparam logic [HEAD_W-1:0] HEAD_ZERO     = 15'd0;
  localparam logic [HEAD_W-1:0] HEAD_QUARTER  = 15'd5760;
  localparam logic [HEAD_W-1:0] HEAD_HALF     = 15'd11520;
  localparam logic [HEAD_W-1:0] HEAD_3QUARTER = 15'd17280;

  localparam logic [ANGLE_W-1:0] ANGLE_ZERO = 32'h0000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF = 32'h8000_0000;

  // Configuration port
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int REG_LSB = 2;

  typedef enum logic [0:0] {
    REG_X_OFFSET = 1'b0,
    REG_Y_OFFSET = 1'b1
  } reg_idx_t;

  typedef logic [ANGLE_W-1:0] angle_t;

  // Hard-iron offsets
  typedef struct packed {
    logic signed [RD_W-1:0] x_offset;
    logic signed [RD_W-1:0] y_offset;
  } cfg_t;

  // One item in flight through the rotation stages
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    angle_t                  z;
    logic                    fixed;          // axis or zero vector
    logic [HEAD_W-1:0]       fixed_heading;  // heading used when fixed
  } vec_t;

  // atan(2^-i) in binary angle units, rounded
  function automatic angle_t atan_entry(input logic [SHIFT_W-1:0] i);
    angle_t r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = ANGLE_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/chxy_if.sv =====
// Valid/ready channel interfaces for reading items and heading items.
// Depends on chxy_pkg for the field widths.
interface chxy_in_if import chxy_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [RD_W-1:0] x_reading;
  logic signed [RD_W-1:0] y_reading;

  modport source (output valid, output x_reading, output y_reading, input ready);
  modport sink   (input valid, input x_reading, input y_reading, output ready);
endinterface

interface chxy_out_if import chxy_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

// ===== hw/rtl/chxy_cfg.sv =====
// APB-style register file holding the X and Y hard-iron offsets.
// Depends on chxy_pkg for register codes and the cfg_t struct.
module chxy_cfg import chxy_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[REG_LSB]);

  // Write the addressed offset in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset <= '0;
      cfg.y_offset <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_X_OFFSET: cfg.x_offset <= pwdata[RD_W-1:0];
        REG_Y_OFFSET: cfg.y_offset <= pwdata[RD_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed offset, sign-extended
  always_comb begin
    case (idx)
      REG_X_OFFSET: prdata = DATA_W'(cfg.x_offset);
      REG_Y_OFFSET: prdata = DATA_W'(cfg.y_offset);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/chxy_prep.sv =====
// Front stage: subtract offsets, flag axis and zero vectors, fold the
// vector into the right half plane. Depends on chxy_pkg.
module chxy_prep import chxy_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [RD_W-1:0] x_reading,
  input  logic signed [RD_W-1:0] y_reading,
  input  cfg_t                   cfg,
  output logic                   out_valid,
  output vec_t                   out_vec
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [VEC_W-1:0]  ex;
  logic signed [VEC_W-1:0]  ey;
  vec_t                     vec_next;

  assign dx = DIFF_W'(x_reading) - DIFF_W'(cfg.x_offset);
  assign dy = DIFF_W'(y_reading) - DIFF_W'(cfg.y_offset);
  assign ex = VEC_W'(dx) <<< FRAC_BITS;
  assign ey = VEC_W'(dy) <<< FRAC_BITS;

  // Negate a left-half vector and start the angle at half a turn
  always_comb begin
    if (dx < 0) begin
      vec_next.x = -ex;
      vec_next.y = -ey;
      vec_next.z = ANGLE_HALF;
    end else begin
      vec_next.x = ex;
      vec_next.y = ey;
      vec_next.z = ANGLE_ZERO;
    end
    // On an axis the heading is known outright
    if (dy == 0) begin
      vec_next.fixed         = 1'b1;
      vec_next.fixed_heading = (dx < 0) ? HEAD_HALF : HEAD_ZERO;
    end else if (dx == 0) begin
      vec_next.fixed         = 1'b1;
      vec_next.fixed_heading = (dy > 0) ? HEAD_QUARTER : HEAD_3QUARTER;
    end else begin
      vec_next.fixed         = 1'b0;
      vec_next.fixed_heading = HEAD_ZERO;
    end
  end

  // Register the item when the pipeline advances
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

// ===== hw/rtl/chxy_step.sv =====
// One registered CORDIC vectoring micro-rotation.
// Depends on chxy_pkg for vec_t and widths.
module chxy_step import chxy_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [SHIFT_W-1:0] shift,
  input  angle_t             angle,
  input  logic               in_valid,
  input  vec_t               in_vec,
  output logic               out_valid,
  output vec_t               out_vec
);

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  vec_t                    vec_next;

  assign xs = in_vec.x >>> shift;
  assign ys = in_vec.y >>> shift;

  // Rotate toward the X axis, both updates from the old vector
  always_comb begin
    vec_next = in_vec;
    if (!in_vec.y[VEC_W-1]) begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + angle;
    end else begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

// ===== hw/rtl/chxy_scale.sv =====
// Back end: scale the binary angle to 1/64 degree, or take the axis
// heading, and drive the output register. Depends on chxy_pkg.
module chxy_scale import chxy_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vec_t              in_vec,
  output logic              out_valid,
  output logic [HEAD_W-1:0] heading
);

  logic [PROD_W-1:0] prod;
  logic              prod_valid;
  logic              prod_fixed;
  logic [HEAD_W-1:0] prod_fixed_heading;
  logic [HEAD_W-1:0] heading_next;

  // Multiply the angle by one turn in 1/64 degree
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod               <= PROD_W'(in_vec.z) * PROD_W'(FULL_TURN);
      prod_fixed         <= in_vec.fixed;
      prod_fixed_heading <= in_vec.fixed_heading;
    end
  end

  // Keep the top bits, or take the axis heading
  assign heading_next = prod_fixed ? prod_fixed_heading : prod[PROD_W-1:ANGLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= heading_next;
    end
  end

endmodule

// ===== hw/rtl/compass_heading_from_xy.sv =====
// Compass heading from one X/Y magnetometer reading.
// Channel sample carries x_reading and y_reading (13-bit signed); channel
// result carries heading (15-bit unsigned, 1/64 degree, 0 to 23039).
// Both use valid/ready; an item moves when valid and ready are both high.
// The APB port holds x_offset (address 0) and y_offset (address 4), which
// are subtracted from each reading before the angle is taken.
// The datapath is one offset stage, one register stage per CORDIC
// micro-rotation (16), one multiply stage and the output register.
// One item is taken every cycle as long as the receiver takes results.
// The whole pipeline advances on one enable, high while the output
// register is empty or being taken; when the receiver stalls with a
// result waiting, every stage holds and sample.ready drops.
// Reset (synchronous, active high) empties the pipeline and clears both
// offsets to zero.
// Depends on chxy_pkg, chxy_if, chxy_cfg, chxy_prep, chxy_step, chxy_scale.
module compass_heading_from_xy import chxy_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  chxy_in_if.sink           sample,
  chxy_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic advance;
  logic vld [NUM_STEPS+1];
  vec_t vec [NUM_STEPS+1];

  // Advance when the output register is free or being taken
  assign advance      = !result.valid || result.ready;
  assign sample.ready = advance;

  chxy_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  chxy_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (sample.valid),
    .x_reading (sample.x_reading),
    .y_reading (sample.y_reading),
    .cfg       (cfg),
    .out_valid (vld[0]),
    .out_vec   (vec[0])
  );

  // One rotation stage per micro-rotation step
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    chxy_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .shift     (SHIFT_W'(i)),
      .angle     (atan_entry(SHIFT_W'(i))),
      .in_valid  (vld[i]),
      .in_vec    (vec[i]),
      .out_valid (vld[i+1]),
      .out_vec   (vec[i+1])
    );
  end

  chxy_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (vld[NUM_STEPS]),
    .in_vec    (vec[NUM_STEPS]),
    .out_valid (result.valid),
    .heading   (result.heading)
  );

`ifndef SYNTH
  // Heading always lies below one full turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading < FULL_TURN))
    else $error("heading out of range");

  // A waiting result blocks new readings
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !sample.ready)
    else $error("reading accepted while result stalled");

  // A stall holds the first stage in place
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (vld[0] == $past(vld[0])))
    else $error("pipeline moved during stall");

  // A write to x_offset lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (reg_idx_t'(paddr[REG_LSB]) == REG_X_OFFSET))
      |=> (cfg.x_offset == $past(pwdata[RD_W-1:0])))
    else $error("x_offset write lost");
`endif

endmodule
